[hw/rtl/wat_pkg.sv]
`default_nettype none

package wat_pkg;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_REFRESH = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    // Payload of one table slot, held in the slot memory
    typedef struct packed {
        logic [7:0] id;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] days;
        logic       once;
    } slot_entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take the input word, reset the scan
        logic rd;       // read the slot at the scan index
        logic eval;     // evaluate the slot just read, advance the scan
        logic write;    // commit an add to its chosen slot
        logic done;     // load the completion word
    } wat_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic skip;       // input word is a tick before any refresh
        logic is_add;     // word in progress is an add
        logic scan_last;  // scan index sits on the final slot
        logic out_free;   // output register can take a word this cycle
    } wat_sts_t;

    // Mask bit of the given weekday; weekday seven matches nothing
    function automatic logic today_bit(input logic [6:0] days, input logic [2:0] wday);
        logic r;
        r = 1'b0;
        if (wday != 3'd7)
        begin
            r = days[wday];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/weekly_alarm_table.sv]
`default_nettype none

// Weekly alarm table. Holds TABLE_DEPTH alarms, each with an id, an hour and
// minute, a weekday mask (bit 0 is Sunday) and on, one-shot and armed-today
// flags. An input word carries one action: add (replace the alarm with the
// same id, else take the lowest free slot, arming it if today's mask bit is
// set; status 1 when the table is full), remove (turn the alarm off; status 2
// for an unknown id), refresh (store the date, free alarms that are off,
// re-arm the rest by weekday) or tick (refresh first on a change of day, then
// fire every armed, on alarm matching the hour and minute, in slot order).
// A tick before the first refresh does nothing. Every input word ends with
// one completion word (result_kind 0, last 1); a tick puts one fired word
// (result_kind 1, fired_id set, last 0) before it for each alarm fired.
// One word is handled at a time. Each word but a tick before the first
// refresh walks every slot through the single read port of the slot memory,
// a read step and an evaluate step per slot; an add then has a write step.
// The evaluate and completion steps wait while the output register holds a
// word not yet taken. The next word is taken while the completion word still
// waits in the output register. No clearing pass is needed after reset.
module weekly_alarm_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    input  wire logic [7:0] alarm_tag,
    input  wire logic [4:0] alarm_hour,
    input  wire logic [5:0] alarm_minute,
    input  wire logic [6:0] weekday_mask,
    input  wire logic       alarm_enabled,
    input  wire logic       fire_once,
    input  wire logic [4:0] now_day,
    input  wire logic [2:0] now_weekday,
    input  wire logic [4:0] now_hour,
    input  wire logic [5:0] now_minute,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            result_kind,
    output logic [7:0]      fired_id,
    output logic [1:0]      status,
    output logic            last
);
    import wat_pkg::*;

    wat_cmd_t cmd;
    wat_sts_t sts;

    // sequence the scan: capture, read and evaluate each slot, commit, complete
    wat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot flags, slot memory, date and output register
    wat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .alarm_tag     (alarm_tag),
        .alarm_hour    (alarm_hour),
        .alarm_minute  (alarm_minute),
        .weekday_mask  (weekday_mask),
        .alarm_enabled (alarm_enabled),
        .fire_once     (fire_once),
        .now_day       (now_day),
        .now_weekday   (now_weekday),
        .now_hour      (now_hour),
        .now_minute    (now_minute),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .fired_id      (fired_id),
        .status        (status),
        .last          (last)
    );

endmodule

`default_nettype wire

[hw/rtl/wat_ctrl.sv]
`default_nettype none

module wat_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire wat_pkg::wat_sts_t sts,
    output wat_pkg::wat_cmd_t    cmd
);
    import wat_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.skip ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // hold while the output register is still occupied
                if (sts.out_free)
                begin
                    cmd.eval = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = sts.is_add ? ST_WRITE : ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wat_datapath.sv]
`default_nettype none

module wat_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wat_pkg::wat_cmd_t cmd,
    output wat_pkg::wat_sts_t      sts,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        alarm_tag,
    input  wire logic [4:0]        alarm_hour,
    input  wire logic [5:0]        alarm_minute,
    input  wire logic [6:0]        weekday_mask,
    input  wire logic              alarm_enabled,
    input  wire logic              fire_once,
    input  wire logic [4:0]        now_day,
    input  wire logic [2:0]        now_weekday,
    input  wire logic [4:0]        now_hour,
    input  wire logic [5:0]        now_minute,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   result_kind,
    output logic [7:0]             fired_id,
    output logic [1:0]             status,
    output logic                   last
);
    import wat_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // captured input word
    action_t     act_reg;
    slot_entry_t new_reg;
    logic        en_reg;
    logic [4:0]  nh_reg;
    logic [5:0]  nm_reg;
    logic        ref_reg;

    // scan
    logic [IW-1:0] idx_reg;
    slot_entry_t   rd_reg;
    logic          hit_reg;
    logic          hit_next;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] hit_idx_next;
    logic          free_reg;
    logic          free_next;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] free_idx_next;

    // per-slot flags
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [TABLE_DEPTH-1:0] used_next;
    logic [TABLE_DEPTH-1:0] on_reg;
    logic [TABLE_DEPTH-1:0] on_next;
    logic [TABLE_DEPTH-1:0] armed_reg;
    logic [TABLE_DEPTH-1:0] armed_next;

    // date
    logic       date_known_reg;
    logic [4:0] stored_day_reg;
    logic [2:0] stored_wd_reg;
    logic       date_load;

    // slot payload memory
    slot_entry_t mem [TABLE_DEPTH];

    // output register
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_id_reg;
    logic [1:0] out_status_reg;
    logic       out_last_reg;

    // evaluation of the slot at the scan index
    logic          used_i;
    logic          on_i;
    logic          armed_i;
    logic          id_match;
    logic          used_eff;
    logic          armed_eff;
    logic          fire;
    logic [IW-1:0] wr_idx;
    logic          wr_en;
    logic [1:0]    done_status;

    assign used_i   = used_reg[idx_reg];
    assign on_i     = on_reg[idx_reg];
    assign armed_i  = armed_reg[idx_reg];
    assign id_match = used_i && (rd_reg.id == new_reg.id);

    // a day change on a tick frees off alarms and re-arms by weekday first
    assign used_eff  = ref_reg ? (used_i && on_i) : used_i;
    assign armed_eff = ref_reg ? (used_eff && today_bit(rd_reg.days, stored_wd_reg)) : armed_i;
    assign fire      = used_eff && armed_eff && on_i
                       && (rd_reg.hour == nh_reg) && (rd_reg.minute == nm_reg);

    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign wr_en  = cmd.write && (hit_reg || free_reg);

    assign date_load = (action_t'(action) == ACT_REFRESH)
                       || ((action_t'(action) == ACT_TICK) && date_known_reg
                           && (now_day != stored_day_reg));

    assign sts.skip      = (action_t'(action) == ACT_TICK) && !date_known_reg;
    assign sts.is_add    = (act_reg == ACT_ADD);
    assign sts.scan_last = (idx_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (act_reg)
            ACT_ADD:    done_status = (hit_reg || free_reg) ? STATUS_OK : STATUS_FULL;
            ACT_REMOVE: done_status = hit_reg ? STATUS_OK : STATUS_NOT_FOUND;
            default:    done_status = STATUS_OK;
        endcase
    end

    always_comb
    begin
        used_next     = used_reg;
        on_next       = on_reg;
        armed_next    = armed_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (cmd.capture)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        if (cmd.eval)
        begin
            case (act_reg)
                ACT_ADD:
                begin
                    if (id_match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_reg;
                    end
                    if (!used_i && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                end
                ACT_REMOVE:
                begin
                    if (id_match)
                    begin
                        hit_next         = 1'b1;
                        on_next[idx_reg] = 1'b0;
                    end
                end
                ACT_REFRESH:
                begin
                    used_next[idx_reg]  = used_i && on_i;
                    armed_next[idx_reg] = used_i && on_i
                                          && today_bit(rd_reg.days, stored_wd_reg);
                end
                ACT_TICK:
                begin
                    used_next[idx_reg]  = used_eff;
                    armed_next[idx_reg] = armed_eff && !fire;
                    if (fire && rd_reg.once)
                    begin
                        on_next[idx_reg] = 1'b0;
                    end
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
        if (wr_en)
        begin
            used_next[wr_idx]  = 1'b1;
            on_next[wr_idx]    = en_reg;
            armed_next[wr_idx] = today_bit(new_reg.days, stored_wd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            on_reg         <= '0;
            armed_reg      <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            idx_reg        <= '0;
            date_known_reg <= 1'b0;
            stored_day_reg <= '0;
            stored_wd_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            on_reg       <= on_next;
            armed_reg    <= armed_next;
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.eval && !sts.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.capture && date_load)
            begin
                date_known_reg <= 1'b1;
                stored_day_reg <= now_day;
                stored_wd_reg  <= now_weekday;
            end
            if (cmd.done || (cmd.eval && (act_reg == ACT_TICK) && fire))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg        <= action_t'(action);
            new_reg.id     <= alarm_tag;
            new_reg.hour   <= alarm_hour;
            new_reg.minute <= alarm_minute;
            new_reg.days   <= weekday_mask;
            new_reg.once   <= fire_once;
            en_reg         <= alarm_enabled;
            nh_reg         <= now_hour;
            nm_reg         <= now_minute;
            ref_reg        <= (action_t'(action) == ACT_TICK) && date_load;
        end
        if (cmd.done)
        begin
            out_kind_reg   <= KIND_DONE;
            out_id_reg     <= '0;
            out_status_reg <= done_status;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.eval && (act_reg == ACT_TICK) && fire)
        begin
            out_kind_reg   <= KIND_FIRED;
            out_id_reg     <= rd_reg.id;
            out_status_reg <= STATUS_OK;
            out_last_reg   <= 1'b0;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= new_reg;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign fired_id    = out_id_reg;
    assign status      = out_status_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

[tb/sv/weekly_alarm_table_tb.sv]
`timescale 1ns / 100ps

module weekly_alarm_table_tb;

    import wat_pkg::*;

    localparam int DEPTH       = 16;
    // Bound on one walk of the whole table, a read and an evaluate step per slot
    localparam int WALK_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_WORDS = 240;

    // One input word, field for field as the ports carry it
    typedef struct packed {
        action_t    act;
        logic [7:0] id;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] mask;
        logic       en;
        logic       once;
        logic [4:0] day;
        logic [2:0] wday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } command_t;

    // One result word
    typedef struct {
        logic       kind;
        logic [7:0] id;
        logic [1:0] st;
        logic       fin;
    } outcome_t;

    // Shadow of the alarm table: applies each accepted command and queues the
    // result words it must cause, then checks the block's words against them.
    class alarm_ledger;
        bit         used  [DEPTH];
        bit         on    [DEPTH];
        bit         once  [DEPTH];
        bit         armed [DEPTH];
        bit [7:0]   ids   [DEPTH];
        bit [4:0]   hr    [DEPTH];
        bit [5:0]   mn    [DEPTH];
        bit [6:0]   days  [DEPTH];
        bit         dated;
        bit [4:0]   day_q;
        bit [2:0]   wday_q;
        outcome_t   owed[$];
        int         errors;
        int         words_seen;
        int         fired_total;
        int         full_total;
        int         unknown_total;

        // Weekday seven falls on the zero pad bit and matches nothing
        function bit on_today(bit [6:0] m);
            bit [7:0] wide;
            wide = {1'b0, m};
            return wide[wday_q];
        endfunction

        function int slot_of(bit [7:0] id);
            int s;
            s = -1;
            for (int i = DEPTH - 1; i >= 0; i--)
            begin
                if (used[i] && ids[i] == id)
                begin
                    s = i;
                end
            end
            return s;
        endfunction

        function void roll_date(bit [4:0] d, bit [2:0] w);
            day_q  = d;
            wday_q = w;
            dated  = 1'b1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (used[i] && !on[i])
                begin
                    used[i] = 1'b0;
                end
                armed[i] = used[i] ? on_today(days[i]) : 1'b0;
            end
        endfunction

        function void owe(logic kind, logic [7:0] id, logic [1:0] st, logic fin);
            outcome_t o;
            o.kind = kind;
            o.id   = id;
            o.st   = st;
            o.fin  = fin;
            owed.push_back(o);
        endfunction

        function void take_command(command_t c);
            int s;
            logic [1:0] st;
            st = STATUS_OK;
            s  = -1;
            case (c.act)
                ACT_ADD:
                begin
                    s = slot_of(c.id);
                    for (int i = 0; i < DEPTH && s < 0; i++)
                    begin
                        if (!used[i])
                        begin
                            s = i;
                        end
                    end
                    if (s < 0)
                    begin
                        st = STATUS_FULL;
                        full_total++;
                    end
                    else
                    begin
                        used[s]  = 1'b1;
                        ids[s]   = c.id;
                        hr[s]    = c.hour;
                        mn[s]    = c.minute;
                        days[s]  = c.mask;
                        on[s]    = c.en;
                        once[s]  = c.once;
                        armed[s] = on_today(c.mask);
                    end
                end
                ACT_REMOVE:
                begin
                    s = slot_of(c.id);
                    if (s < 0)
                    begin
                        st = STATUS_NOT_FOUND;
                        unknown_total++;
                    end
                    else
                    begin
                        on[s] = 1'b0;
                    end
                end
                ACT_REFRESH:
                begin
                    roll_date(c.day, c.wday);
                end
                default:
                begin
                    if (dated)
                    begin
                        if (c.day != day_q)
                        begin
                            roll_date(c.day, c.wday);
                        end
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (used[i] && armed[i] && on[i] &&
                                hr[i] == c.now_hour && mn[i] == c.now_minute)
                            begin
                                owe(KIND_FIRED, ids[i], STATUS_OK, 1'b0);
                                fired_total++;
                                armed[i] = 1'b0;
                                if (once[i])
                                begin
                                    on[i] = 1'b0;
                                end
                            end
                        end
                    end
                end
            endcase
            owe(KIND_DONE, 8'h00, st, 1'b1);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic kind, logic [7:0] id, logic [1:0] st, logic fin);
            outcome_t o;
            words_seen++;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual kind %0h id %0h",
                         $time, kind, id);
                errors++;
            end
            else
            begin
                o = owed.pop_front();
                compare_field("result_kind", {7'd0, o.kind}, {7'd0, kind});
                compare_field("fired_id", o.id, id);
                compare_field("status", {6'd0, o.st}, {6'd0, st});
                compare_field("last", {7'd0, o.fin}, {7'd0, fin});
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] action = 2'd0;
    logic [7:0] alarm_tag = 8'd0;
    logic [4:0] alarm_hour = 5'd0;
    logic [5:0] alarm_minute = 6'd0;
    logic [6:0] weekday_mask = 7'd0;
    logic       alarm_enabled = 1'b0;
    logic       fire_once = 1'b0;
    logic [4:0] now_day = 5'd0;
    logic [2:0] now_weekday = 3'd0;
    logic [4:0] now_hour = 5'd0;
    logic [5:0] now_minute = 6'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] fired_id;
    logic [1:0] status;
    logic       last;

    alarm_ledger ledger = new();

    int cycle_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;
    int rx_left     = 0;
    int rx_mode     = 0;

    // A few shared alarm times, so that ticks actually hit stored alarms
    bit [4:0] common_hour [3] = '{5'd7, 5'd12, 5'd23};
    bit [5:0] common_min  [3] = '{6'd30, 6'd0, 6'd59};

    weekly_alarm_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .alarm_tag     (alarm_tag),
        .alarm_hour    (alarm_hour),
        .alarm_minute  (alarm_minute),
        .weekday_mask  (weekday_mask),
        .alarm_enabled (alarm_enabled),
        .fire_once     (fire_once),
        .now_day       (now_day),
        .now_weekday   (now_weekday),
        .now_hour      (now_hour),
        .now_minute    (now_minute),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .fired_id      (fired_id),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: drop the run if the block stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit, %0d result words still owed",
                     $time, ledger.owed.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: check each accepted result word, then pick ready for the next
    // cycle. Ready follows modes that last a random stretch: always ready,
    // coin toss, a periodic mode from the cycle counter, and a mostly stalled mode.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            ledger.check_word(result_kind, fired_id, status, last);
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycle_count % 5 == 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Fill every field with noise; callers then overwrite the fields that matter
    function automatic command_t noise_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[48:0];
    endfunction

    // Hold the word until accepted, note it, then pace the sender: bursts of
    // random length, random gaps between them
    task automatic send_word(command_t c);
        int gap;
        in_valid      <= 1'b1;
        action        <= c.act;
        alarm_tag     <= c.id;
        alarm_hour    <= c.hour;
        alarm_minute  <= c.minute;
        weekday_mask  <= c.mask;
        alarm_enabled <= c.en;
        fire_once     <= c.once;
        now_day       <= c.day;
        now_weekday   <= c.wday;
        now_hour      <= c.now_hour;
        now_minute    <= c.now_minute;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        ledger.take_command(c);
        words_sent++;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        burst_left--;
        if (gap > 0)
        begin
            // Drop valid only when a real gap follows, never lower and raise it
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic enter_alarm(logic [7:0] id, logic [4:0] h, logic [5:0] m,
                               logic [6:0] mask, logic en, logic once);
        command_t c;
        c        = noise_word();
        c.act    = ACT_ADD;
        c.id     = id;
        c.hour   = h;
        c.minute = m;
        c.mask   = mask;
        c.en     = en;
        c.once   = once;
        send_word(c);
    endtask

    task automatic drop_alarm(logic [7:0] id);
        command_t c;
        c     = noise_word();
        c.act = ACT_REMOVE;
        c.id  = id;
        send_word(c);
    endtask

    task automatic set_date(logic [4:0] d, logic [2:0] w);
        command_t c;
        c      = noise_word();
        c.act  = ACT_REFRESH;
        c.day  = d;
        c.wday = w;
        send_word(c);
    endtask

    task automatic tick(logic [4:0] d, logic [2:0] w, logic [4:0] h, logic [5:0] m);
        command_t c;
        c            = noise_word();
        c.act        = ACT_TICK;
        c.day        = d;
        c.wday       = w;
        c.now_hour   = h;
        c.now_minute = m;
        send_word(c);
    endtask

    // Mostly a small pool of ids so that adds replace and the table fills up
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        if ($urandom_range(0, 9) == 0)
        begin
            id = 8'($urandom_range(0, 255));
        end
        else
        begin
            id = 8'(8'h80 + $urandom_range(0, 19));
        end
        return id;
    endfunction

    initial
    begin
        int r;
        int k;
        logic [4:0] h;
        logic [5:0] m;
        logic [6:0] mask;
        logic [4:0] d;
        logic [2:0] w;

        // Hold reset at the start, once only
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        tick(5'd9, 3'd2, 5'd0, 6'd0);                    // no date yet: ignored
        enter_alarm(8'h00, 5'd0, 6'd0, 7'h01, 1'b1, 1'b0);  // arms by Sunday before any date
        enter_alarm(8'hFF, 5'd31, 6'd63, 7'h7F, 1'b1, 1'b1); // out-of-range time, one-shot
        drop_alarm(8'h55);                               // unknown id
        set_date(5'd5, 3'd0);
        tick(5'd5, 3'd0, 5'd0, 6'd0);
        tick(5'd5, 3'd0, 5'd31, 6'd63);                  // one-shot fires, turns off
        tick(5'd5, 3'd0, 5'd31, 6'd63);                  // must stay quiet
        enter_alarm(8'h00, 5'd0, 6'd0, 7'h01, 1'b1, 1'b0);  // replace in place, re-arm
        tick(5'd5, 3'd0, 5'd0, 6'd0);                    // fires once, no stale copy
        drop_alarm(8'hFF);                               // off but still known
        set_date(5'd6, 3'd7);                            // weekday seven, frees the off alarm
        drop_alarm(8'hFF);                               // gone now
        tick(5'd0, 3'd6, 5'd0, 6'd0);                    // day change inside a tick
        for (k = 0; k < DEPTH - 1; k++)
        begin
            enter_alarm(8'(8'h80 + k), 5'd23, 6'd59, 7'h7F, 1'b1, k[0]);
        end
        enter_alarm(8'hC3, 5'd23, 6'd59, 7'h7F, 1'b1, 1'b0); // table full
        enter_alarm(8'h00, 5'd23, 6'd59, 7'h7F, 1'b1, 1'b0); // replace on a full table
        tick(5'd0, 3'd6, 5'd23, 6'd59);                  // every slot fires

        // Random part: mostly dated traffic around a few shared times
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 80)
            begin
                h = common_hour[$urandom_range(0, 2)];
                m = common_min[$urandom_range(0, 2)];
                if (h == 5'd23)
                begin
                    m = 6'd59;
                end
            end
            else
            begin
                h = 5'($urandom_range(0, 31));
                m = 6'($urandom_range(0, 63));
            end
            if (r < 5)
            begin
                send_word(noise_word());
            end
            else if (r < 35)
            begin
                mask = ($urandom_range(0, 9) < 4) ? 7'h7F : 7'($urandom_range(0, 127));
                enter_alarm(pick_id(), h, m, mask, ($urandom_range(0, 9) < 8),
                            1'($urandom_range(0, 1)));
            end
            else if (r < 47)
            begin
                drop_alarm(pick_id());
            end
            else if (r < 54)
            begin
                set_date(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
            end
            else
            begin
                d = ledger.day_q;
                w = ledger.wday_q;
                if ($urandom_range(0, 99) < 15)
                begin
                    d = 5'($urandom_range(0, 31));
                    w = 3'($urandom_range(0, 7));
                end
                tick(d, w, h, m);
            end
        end

        // Drain: wait for every owed word, then a full table walk more
        in_valid <= 1'b0;
        while (ledger.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (WALK_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d result words: %0d alarms fired,",
                 words_sent, ledger.words_seen, ledger.fired_total);
        $display("%0d adds refused on a full table, %0d removes of unknown ids, %0d errors.",
                 ledger.full_total, ledger.unknown_total, ledger.errors);
        if (ledger.owed.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time, ledger.owed.size());
        end
        if (ledger.errors == 0 && ledger.owed.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wat_pkg.sv
hw/rtl/wat_ctrl.sv
hw/rtl/wat_datapath.sv
hw/rtl/weekly_alarm_table.sv
tb/sv/weekly_alarm_table_tb.sv
